// ===== rtl/core/pra_pkg.sv =====
package pra_pkg;

  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned SLOT_OUT_W = 6;
  localparam logic [LEN_W-1:0] LEN_MAX = 5'd16;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_DEL    = 2'd1,
    ACT_LOOKUP = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_INVALID = 3'd1,
    STS_EXISTS  = 3'd2,
    STS_FULL    = 3'd3,
    STS_NOROUTE = 3'd4,
    STS_REMOTE  = 3'd5,
    STS_DOWN    = 3'd6,
    STS_MEDIUM  = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] node_id;
    logic [LEN_W-1:0]  prefix_len;
    logic [15:0]       src_node;
    logic [15:0]       frag_limit;
    logic              local_route;
    logic              route_down;
    logic              no_ordered;
    logic              no_reliable;
    logic              ordered_msg;
    logic              reliable_msg;
    logic              remote_allowed;
  } req_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [15:0]           src_node_out;
    logic [15:0]           frag_limit_out;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  prefix_len;
    logic [15:0]       src_node;
    logic [15:0]       frag_limit;
    logic              local_route;
    logic              route_down;
    logic              no_ordered;
    logic              no_reliable;
  } entry_t;

  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] node_id;
    logic [LEN_W-1:0]  prefix_len;
  } tok_t;

  typedef struct packed {
    logic   best_found;
    entry_t best_entry;
    logic   hit_found;
    logic   free_found;
  } acc_t;

  typedef struct packed {
    logic   we;
    logic   clr;
    entry_t entry;
  } commit_t;

  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    return ~({ADDR_W{1'b1}} >> len);
  endfunction

endpackage

// ===== rtl/core/pra_if.sv =====
interface pra_req_if;
  import pra_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pra_rsp_if;
  import pra_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/pra_cell.sv =====
module pra_cell #(
  parameter int unsigned SLOT_W   = 6,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pra_pkg::tok_t       tok_i,
  input  pra_pkg::acc_t       acc_i,
  input  logic [SLOT_W-1:0]   best_slot_i,
  input  logic [SLOT_W-1:0]   hit_slot_i,
  input  logic [SLOT_W-1:0]   free_slot_i,
  input  pra_pkg::commit_t    commit_i,
  input  logic [SLOT_W-1:0]   commit_slot_i,
  output pra_pkg::tok_t       tok_o,
  output pra_pkg::acc_t       acc_o,
  output logic [SLOT_W-1:0]   best_slot_o,
  output logic [SLOT_W-1:0]   hit_slot_o,
  output logic [SLOT_W-1:0]   free_slot_o
);
  import pra_pkg::*;

  localparam logic [SLOT_W-1:0] MyIdx = SLOT_W'(CELL_IDX);

  logic   valid_q;
  entry_t entry_q;
  tok_t   tok_q;
  acc_t   acc_q, acc_d;
  logic [SLOT_W-1:0] best_slot_q, best_slot_d;
  logic [SLOT_W-1:0] hit_slot_q, hit_slot_d;
  logic [SLOT_W-1:0] free_slot_q, free_slot_d;
  logic   sel;
  logic   exact;
  logic   covers;
  logic   take_best;
  logic   take_hit;
  logic   take_free;

  assign sel = (commit_slot_i == MyIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sel && commit_i.we) begin
      valid_q <= 1'b1;
    end else if (sel && commit_i.clr) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel && commit_i.we) begin
      entry_q <= commit_i.entry;
    end
  end

  assign exact  = valid_q && (entry_q.prefix == tok_i.node_id)
                  && (entry_q.prefix_len == tok_i.prefix_len);
  assign covers = valid_q
                  && ((tok_i.node_id & len_mask(entry_q.prefix_len)) == entry_q.prefix);
  assign take_best = covers && (!acc_i.best_found
                     || (entry_q.prefix_len > acc_i.best_entry.prefix_len));
  assign take_hit  = exact && !acc_i.hit_found;
  assign take_free = !valid_q && !acc_i.free_found;

  always_comb begin
    acc_d       = acc_i;
    best_slot_d = best_slot_i;
    hit_slot_d  = hit_slot_i;
    free_slot_d = free_slot_i;
    if (take_best) begin
      acc_d.best_found = 1'b1;
      acc_d.best_entry = entry_q;
      best_slot_d      = MyIdx;
    end
    if (take_hit) begin
      acc_d.hit_found = 1'b1;
      hit_slot_d      = MyIdx;
    end
    if (take_free) begin
      acc_d.free_found = 1'b1;
      free_slot_d      = MyIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    best_slot_q <= best_slot_d;
    hit_slot_q  <= hit_slot_d;
    free_slot_q <= free_slot_d;
  end

  assign tok_o       = tok_q;
  assign acc_o       = acc_q;
  assign best_slot_o = best_slot_q;
  assign hit_slot_o  = hit_slot_q;
  assign free_slot_o = free_slot_q;

endmodule

// ===== rtl/core/prefix_route_table.sv =====
// Longest-prefix route table over 16-bit node addresses, held in a row of
// ROUTE_SLOTS cells. Each request (add, delete or lookup) walks the row one
// cell per cycle, collecting the longest match, the exact match and the
// lowest free slot; at the end of the row the result is decided and an add
// or delete is written back to the chosen cell. A new request is accepted
// only once the previous one has walked the whole cell row and its result
// has been loaded into the response register; a finished response waits in
// that register while the next request is taken. The table is empty after reset.
module prefix_route_table #(
  parameter int unsigned ROUTE_SLOTS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pra_req_if.sink      req_i,
  pra_rsp_if.source    rsp_o
);
  import pra_pkg::*;

  localparam int unsigned SlotW = $clog2(ROUTE_SLOTS);

  tok_t              tok [ROUTE_SLOTS+1];
  acc_t              acc [ROUTE_SLOTS+1];
  logic [SlotW-1:0]  best_slot [ROUTE_SLOTS+1];
  logic [SlotW-1:0]  hit_slot [ROUTE_SLOTS+1];
  logic [SlotW-1:0]  free_slot [ROUTE_SLOTS+1];
  logic [ROUTE_SLOTS-1:0] tok_vld;

  state_e            state_q, state_d;
  req_t              req_q;
  acc_t              done_acc_q;
  logic [SlotW-1:0]  done_best_q, done_hit_q, done_free_q;
  rsp_t              rsp_q, rsp_d;
  logic              rsp_vld_q, rsp_vld_d;
  commit_t           commit;
  logic [SlotW-1:0]  commit_slot;
  logic              accept;
  logic              out_free;
  logic              load_rsp;
  logic              tail_vld;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !rsp_vld_q || rsp_o.ready;
  assign tail_vld = tok[ROUTE_SLOTS].vld;

  assign tok[0]       = '{vld: accept, node_id: req_i.payload.node_id,
                          prefix_len: req_i.payload.prefix_len};
  assign acc[0]       = '0;
  assign best_slot[0] = '0;
  assign hit_slot[0]  = '0;
  assign free_slot[0] = '0;

  for (genvar g = 0; g < ROUTE_SLOTS; g++) begin : g_cell
    pra_cell #(
      .SLOT_W   (SlotW),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .tok_i         (tok[g]),
      .acc_i         (acc[g]),
      .best_slot_i   (best_slot[g]),
      .hit_slot_i    (hit_slot[g]),
      .free_slot_i   (free_slot[g]),
      .commit_i      (commit),
      .commit_slot_i (commit_slot),
      .tok_o         (tok[g+1]),
      .acc_o         (acc[g+1]),
      .best_slot_o   (best_slot[g+1]),
      .hit_slot_o    (hit_slot[g+1]),
      .free_slot_o   (free_slot[g+1])
    );
    assign tok_vld[g] = tok[g+1].vld;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (tail_vld) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = (state_q == S_IDLE);
    load_rsp    = (state_q == S_DONE) && out_free;
  end

  always_comb begin
    rsp_d        = '0;
    rsp_d.status = STS_INVALID;
    commit       = '0;
    commit.entry = '{prefix: req_q.node_id, prefix_len: req_q.prefix_len,
                     src_node: req_q.src_node, frag_limit: req_q.frag_limit,
                     local_route: req_q.local_route, route_down: req_q.route_down,
                     no_ordered: req_q.no_ordered, no_reliable: req_q.no_reliable};
    commit_slot  = '0;
    case (action_e'(req_q.action))
      ACT_ADD: begin
        if ((req_q.prefix_len > LEN_MAX)
            || ((req_q.node_id & ~len_mask(req_q.prefix_len)) != '0)) begin
          rsp_d.status = STS_INVALID;
        end else if (done_acc_q.hit_found) begin
          rsp_d.status = STS_EXISTS;
          rsp_d.slot   = SLOT_OUT_W'(done_hit_q);
        end else if (done_acc_q.free_found) begin
          rsp_d.status = STS_OK;
          rsp_d.slot   = SLOT_OUT_W'(done_free_q);
          commit.we    = load_rsp;
          commit_slot  = done_free_q;
        end else begin
          rsp_d.status = STS_FULL;
        end
      end
      ACT_DEL: begin
        if (req_q.prefix_len > LEN_MAX) begin
          rsp_d.status = STS_INVALID;
        end else if (!done_acc_q.hit_found) begin
          rsp_d.status = STS_NOROUTE;
        end else begin
          rsp_d.status = STS_OK;
          rsp_d.slot   = SLOT_OUT_W'(done_hit_q);
          commit.clr   = load_rsp;
          commit_slot  = done_hit_q;
        end
      end
      ACT_LOOKUP: begin
        if (!done_acc_q.best_found) begin
          rsp_d.status = STS_NOROUTE;
        end else begin
          rsp_d.slot = SLOT_OUT_W'(done_best_q);
          if (!req_q.remote_allowed && !done_acc_q.best_entry.local_route) begin
            rsp_d.status = STS_REMOTE;
          end else if (done_acc_q.best_entry.route_down) begin
            rsp_d.status = STS_DOWN;
          end else if ((req_q.ordered_msg && done_acc_q.best_entry.no_ordered)
                       || (req_q.reliable_msg && done_acc_q.best_entry.no_reliable)) begin
            rsp_d.status = STS_MEDIUM;
          end else begin
            rsp_d.status         = STS_OK;
            rsp_d.src_node_out   = done_acc_q.best_entry.src_node;
            rsp_d.frag_limit_out = done_acc_q.best_entry.frag_limit;
          end
        end
      end
      default: begin
        rsp_d.status = STS_INVALID;
      end
    endcase
  end

  assign rsp_vld_d = load_rsp || (rsp_vld_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i.payload;
    end
    if ((state_q == S_SEARCH) && tail_vld) begin
      done_acc_q  <= acc[ROUTE_SLOTS];
      done_best_q <= best_slot[ROUTE_SLOTS];
      done_hit_q  <= hit_slot[ROUTE_SLOTS];
      done_free_q <= free_slot[ROUTE_SLOTS];
    end
    if (load_rsp) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.payload = rsp_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(commit.we && commit.clr))
    else $error("slot written and cleared in the same cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one request in the cell row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##ROUTE_SLOTS tail_vld)
    else $error("request did not reach the end of the cell row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_vld_q) |-> $past(state_q == S_DONE))
    else $error("response raised without a finished request");
`endif

endmodule
